[hw/rtl/pll_pkg.sv]
// ----------------------------------------------------------------------------
// pll_pkg
// Shared types and constants for the price level ladder.
// ----------------------------------------------------------------------------
package pll_pkg;

  localparam int MAX_LEVELS = 64;
  localparam int IDX_W      = $clog2(MAX_LEVELS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int QBIT_W     = 3;            // quotient bit counter, quotient has CNT_W bits
  localparam int SHIFT_W    = 64 + CNT_W - 1;

  localparam logic [0:0] REQ_SET   = 1'b0;
  localparam logic [0:0] REQ_QUERY = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_PRICE = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  localparam logic [1:0] REG_FLOOR = 2'd0;
  localparam logic [1:0] REG_TICK  = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  typedef struct packed {
    logic              req_type;
    logic signed [63:0] price;
    logic [63:0]       quantity;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [63:0]        level_quantity;
    logic [63:0]        book_total;
    logic [63:0]        occupied_mask;
    logic               book_nonempty;
    logic signed [63:0] lowest_price;
    logic [63:0]        lowest_quantity;
    logic signed [63:0] highest_price;
    logic [63:0]        highest_quantity;
  } out_item_t;

  // Classified request handed from front to back.
  typedef struct packed {
    logic              req_type;
    logic              ok;
    logic [IDX_W-1:0]  idx;
    logic [63:0]       quantity;
  } op_t;

  typedef enum logic [1:0] {FE_IDLE, FE_DIV, FE_PUSH} fe_state_t;

  typedef enum logic [2:0] {BE_IDLE, BE_RD, BE_UPD, BE_LO, BE_HI, BE_FIN} be_state_t;

  function automatic logic [IDX_W-1:0] lowest_bit(input logic [MAX_LEVELS-1:0] m);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
      if (m[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] highest_bit(input logic [MAX_LEVELS-1:0] m);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (m[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

endpackage

[hw/rtl/pll_front.sv]
// ----------------------------------------------------------------------------
// pll_front
// Accepts requests and maps each price to a grid level by serial division.
// ----------------------------------------------------------------------------
module pll_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  pll_pkg::in_item_t        in_data,
  input  logic signed [63:0]       floor_i,
  input  logic [62:0]              tick_i,
  input  logic [pll_pkg::CNT_W-1:0] count_i,
  output logic                     op_valid,
  output pll_pkg::op_t             op_data,
  input  logic                     op_ready
);
  import pll_pkg::*;

  fe_state_t          state_r, state_nxt;
  logic               req_r;
  logic               below_r;
  logic [63:0]        qty_r;
  logic [63:0]        rem_r;
  logic [CNT_W-1:0]   quo_r;
  logic [QBIT_W-1:0]  k_r;
  logic [SHIFT_W-1:0] cand;
  logic               fits;

  assign cand = SHIFT_W'({1'b0, tick_i}) << k_r;
  assign fits = SHIFT_W'(rem_r) >= cand;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FE_IDLE: if (in_valid) state_nxt = FE_DIV;
      FE_DIV:  if (k_r == '0) state_nxt = FE_PUSH;
      FE_PUSH: if (op_ready) state_nxt = FE_IDLE;
      default: state_nxt = FE_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = (state_r == FE_IDLE);
    op_valid         = (state_r == FE_PUSH);
    op_data.req_type = req_r;
    op_data.quantity = qty_r;
    op_data.idx      = quo_r[IDX_W-1:0];
    op_data.ok       = !below_r && (rem_r == '0) && (quo_r < count_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Restoring division, one quotient bit a cycle, most significant first.
  always_ff @(posedge clk) begin
    if (state_r == FE_IDLE && in_valid) begin
      req_r   <= in_data.req_type;
      qty_r   <= in_data.quantity;
      below_r <= in_data.price < floor_i;
      rem_r   <= in_data.price - floor_i;
      quo_r   <= '0;
      k_r     <= QBIT_W'(CNT_W - 1);
    end else if (state_r == FE_DIV) begin
      if (fits) begin
        rem_r      <= rem_r - cand[63:0];
        quo_r[k_r] <= 1'b1;
      end
      k_r <= k_r - 1'b1;
    end
  end

endmodule

[hw/rtl/pll_queue.sv]
// ----------------------------------------------------------------------------
// pll_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module pll_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  pll_pkg::op_t wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output pll_pkg::op_t rd_data
);
  import pll_pkg::*;

  op_t        mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

endmodule

[hw/rtl/pll_back.sv]
// ----------------------------------------------------------------------------
// pll_back
// Applies classified requests to the level store and builds results.
// ----------------------------------------------------------------------------
module pll_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               op_valid,
  output logic               op_ready,
  input  pll_pkg::op_t       op_data,
  input  logic signed [63:0] floor_i,
  input  logic [62:0]        tick_i,
  output logic               out_valid,
  input  logic               out_ready,
  output pll_pkg::out_item_t out_data
);
  import pll_pkg::*;

  be_state_t             state_r, state_nxt;
  op_t                   op_r;
  logic [63:0]           mem [MAX_LEVELS];
  logic [MAX_LEVELS-1:0] vld_r;
  logic [MAX_LEVELS-1:0] mask_r;
  logic [63:0]           total_r;
  logic [IDX_W-1:0]      raddr;
  logic [63:0]           rdata_r;
  logic                  rvld_r;
  logic [63:0]           rd_q;
  logic [1:0]            status_r;
  logic [63:0]           lq_r;
  logic [63:0]           prod_r;
  logic [63:0]           lo_price_r;
  logic [63:0]           lo_qty_r;
  logic [IDX_W-1:0]      lo_idx, hi_idx;
  logic [63:0]           rest_total;
  logic                  ovf;
  logic                  do_write;
  logic                  out_valid_r;
  out_item_t             out_r;
  logic                  load_out;

  assign lo_idx      = lowest_bit(mask_r);
  assign hi_idx      = highest_bit(mask_r);
  assign rd_q        = rvld_r ? rdata_r : 64'd0;
  assign rest_total  = total_r - rd_q;
  assign ovf         = op_r.quantity > ~rest_total;
  assign do_write    = (state_r == BE_UPD) && op_r.ok && (op_r.req_type == REQ_SET) && !ovf;
  assign load_out    = (state_r == BE_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BE_IDLE: if (op_valid) state_nxt = BE_RD;
      BE_RD:   state_nxt = BE_UPD;
      BE_UPD:  state_nxt = BE_LO;
      BE_LO:   state_nxt = BE_HI;
      BE_HI:   state_nxt = BE_FIN;
      BE_FIN:  if (load_out) state_nxt = BE_IDLE;
      default: state_nxt = BE_IDLE;
    endcase
  end

  // Pick the read address per state; hold the highest level address while waiting to load the result.
  always_comb begin
    op_ready = (state_r == BE_IDLE);
    case (state_r)
      BE_LO:   raddr = lo_idx;
      BE_HI:   raddr = hi_idx;
      BE_FIN:  raddr = hi_idx;
      default: raddr = op_r.idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BE_IDLE;
      vld_r       <= '0;
      mask_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (do_write) begin
        vld_r[op_r.idx]  <= 1'b1;
        mask_r[op_r.idx] <= (op_r.quantity != '0);
        total_r          <= rest_total + op_r.quantity;
      end
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Level store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (do_write) mem[op_r.idx] <= op_r.quantity;
    rdata_r <= mem[raddr];
    rvld_r  <= vld_r[raddr];
  end

  always_ff @(posedge clk) begin
    if (state_r == BE_IDLE && op_valid) op_r <= op_data;
    if (state_r == BE_UPD) begin
      if (!op_r.ok) begin
        status_r <= ST_BAD_PRICE;
        lq_r     <= '0;
      end else if (op_r.req_type == REQ_SET && ovf) begin
        status_r <= ST_OVERFLOW;
        lq_r     <= rd_q;
      end else if (op_r.req_type == REQ_SET) begin
        status_r <= ST_OK;
        lq_r     <= op_r.quantity;
      end else begin
        status_r <= ST_OK;
        lq_r     <= rd_q;
      end
    end
    if (state_r == BE_LO) prod_r <= {{(64-IDX_W){1'b0}}, lo_idx} * {1'b0, tick_i};
    if (state_r == BE_HI) begin
      lo_price_r <= floor_i + prod_r;
      lo_qty_r   <= rd_q;
      prod_r     <= {{(64-IDX_W){1'b0}}, hi_idx} * {1'b0, tick_i};
    end
    if (load_out) begin
      out_r.status         <= status_r;
      out_r.level_quantity <= lq_r;
      out_r.book_total     <= total_r;
      out_r.occupied_mask  <= mask_r;
      if (mask_r != '0) begin
        out_r.book_nonempty    <= 1'b1;
        out_r.lowest_price     <= lo_price_r;
        out_r.lowest_quantity  <= lo_qty_r;
        out_r.highest_price    <= floor_i + prod_r;
        out_r.highest_quantity <= rd_q;
      end else begin
        out_r.book_nonempty    <= 1'b0;
        out_r.lowest_price     <= '0;
        out_r.lowest_quantity  <= '0;
        out_r.highest_price    <= '0;
        out_r.highest_quantity <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[hw/rtl/price_level_ladder.sv]
// ----------------------------------------------------------------------------
// price_level_ladder
// Price-level book on a fixed-tick grid of up to 64 levels.
// ----------------------------------------------------------------------------
// A request is accepted on in_valid/in_ready and gives exactly one result
// beat on out_valid/out_ready. The front maps the price to a level with a
// restoring divider that yields one quotient bit a cycle, then hands the
// classified request to a two-entry queue. The back steps through each
// request: accept, read the level, apply the set, then read the lowest
// and highest occupied levels through the one read port of the level
// store while one shared multiplier forms their prices, and load the
// result. With both sides overlapped the front sets the sustained rate: it
// accepts, divides a bit at a time and pushes before taking the next request;
// a result beat waits in an output register while the next one is worked.
// The store valid bits are cleared by reset, so no clearing pass is needed.
// Registers sit at byte offsets 0 (price_floor), 8 (tick_size) and
// 16 (level_count) of the 64-bit configuration port; write them only while
// the block is idle. A zero tick acts as one, a level count of zero as one
// and one above 64 as 64.
// ----------------------------------------------------------------------------
module price_level_ladder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pll_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pll_pkg::out_item_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [63:0]        cfg_pwdata,
  output logic [63:0]        cfg_prdata,
  output logic               cfg_pready
);
  import pll_pkg::*;

  logic signed [63:0] floor_r;
  logic [62:0]        tick_r;
  logic [6:0]         count_r;
  logic [62:0]        tick_eff;
  logic [CNT_W-1:0]   count_eff;
  logic [1:0]         reg_sel;
  logic               wr_en;
  logic               q_wr_valid, q_wr_ready, q_rd_valid, q_rd_ready;
  op_t                q_wr_data, q_rd_data;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[4:3];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  // Hold the grid registers; write on the access beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= '0;
      tick_r  <= 63'd1;
      count_r <= 7'd64;
    end else if (wr_en) begin
      case (reg_sel)
        REG_FLOOR: floor_r <= cfg_pwdata;
        REG_TICK:  tick_r  <= cfg_pwdata[62:0];
        REG_COUNT: count_r <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FLOOR: cfg_prdata = floor_r;
      REG_TICK:  cfg_prdata = {1'b0, tick_r};
      REG_COUNT: cfg_prdata = {57'd0, count_r};
      default:   cfg_prdata = '0;
    endcase
  end

  // Clamp the grid to its usable range.
  assign tick_eff = (tick_r == '0) ? 63'd1 : tick_r;
  always_comb begin
    if (count_r == '0)                   count_eff = CNT_W'(1);
    else if (count_r > 7'(MAX_LEVELS))   count_eff = CNT_W'(MAX_LEVELS);
    else                                 count_eff = CNT_W'(count_r);
  end

  pll_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .floor_i  (floor_r),
    .tick_i   (tick_eff),
    .count_i  (count_eff),
    .op_valid (q_wr_valid),
    .op_data  (q_wr_data),
    .op_ready (q_wr_ready)
  );

  pll_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_data  (q_wr_data),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_data  (q_rd_data)
  );

  pll_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (q_rd_valid),
    .op_ready  (q_rd_ready),
    .op_data   (q_rd_data),
    .floor_i   (floor_r),
    .tick_i    (tick_eff),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[tb/price_level_checker.sv]
// ----------------------------------------------------------------------------
// price_level_checker
// Watches the request, result and register ports of the ladder, predicts
// every result beat from its own copy of the grid and book, and counts
// mismatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module price_level_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  pll_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  pll_pkg::out_item_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [63:0]        cfg_pwdata,
  input  logic               cfg_pready,
  output int                 fail_count,
  output int                 open_results
);
  import pll_pkg::*;

  logic [63:0] grid_floor;
  logic [62:0] grid_tick;
  logic [6:0]  grid_count;
  logic [63:0] book_qty [MAX_LEVELS];
  logic [63:0] book_mask;
  logic [63:0] book_sum;
  out_item_t   pending_results [$];

  function automatic logic [63:0] tick_step();
    return (grid_tick == '0) ? 64'd1 : {1'b0, grid_tick};
  endfunction

  function automatic out_item_t apply_request(input in_item_t req);
    out_item_t   res;
    logic [63:0] gap, step, lvl, rest;
    logic [6:0]  span;
    int          idx, lo, hi;
    bit          on_grid;
    res  = '0;
    step = tick_step();
    span = (grid_count == 0) ? 7'd1 : (grid_count > MAX_LEVELS) ? 7'(MAX_LEVELS) : grid_count;
    gap  = req.price - grid_floor;
    lvl  = gap / step;
    on_grid = !($signed(req.price) < $signed(grid_floor)) && (gap % step == 0)
              && (lvl < {57'd0, span});
    idx  = int'(lvl[6:0]);
    if (!on_grid) begin
      res.status = ST_BAD_PRICE;
    end else if (req.req_type == REQ_SET) begin
      rest = book_sum - book_qty[idx];
      if (req.quantity > ~rest) begin
        res.status         = ST_OVERFLOW;
        res.level_quantity = book_qty[idx];
      end else begin
        book_qty[idx]  = req.quantity;
        book_sum       = rest + req.quantity;
        book_mask[idx] = (req.quantity != 0);
        res.status         = ST_OK;
        res.level_quantity = req.quantity;
      end
    end else begin
      res.status         = ST_OK;
      res.level_quantity = book_qty[idx];
    end
    res.book_total    = book_sum;
    res.occupied_mask = book_mask;
    if (book_mask != 0) begin
      lo = -1;
      hi = 0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        if (book_mask[i]) begin
          if (lo < 0) lo = i;
          hi = i;
        end
      end
      res.book_nonempty    = 1'b1;
      res.lowest_price     = grid_floor + 64'(lo) * step;
      res.lowest_quantity  = book_qty[lo];
      res.highest_price    = grid_floor + 64'(hi) * step;
      res.highest_quantity = book_qty[hi];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      grid_floor <= '0;
      grid_tick  <= 63'd1;
      grid_count <= 7'd64;
      book_mask  <= '0;
      book_sum   <= '0;
      for (int i = 0; i < MAX_LEVELS; i++) book_qty[i] <= '0;
      pending_results.delete();
      fail_count   <= 0;
      open_results <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:3])
          REG_FLOOR: grid_floor <= cfg_pwdata;
          REG_TICK:  grid_tick  <= cfg_pwdata[62:0];
          REG_COUNT: grid_count <= cfg_pwdata[6:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) pending_results.push_back(apply_request(in_data));
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat: %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = pending_results.pop_front();
          if (want != out_data) begin
            if (fail_count < 10) begin
              $display("result mismatch at %0t", $realtime);
              $display("  expected %p", want);
              $display("  actual   %p", out_data);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
      open_results <= pending_results.size();
    end
  end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives the price level ladder through a series of grid settings with
// directed and random set/query beats under varying idle patterns; the
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import pll_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count;
  int          open_results;

  // Idle knobs, in percent, changed per phase.
  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;
  // Long receiver hold-off: bump the request counter, the receiver counts it out.
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;

  // Grid as the stimulus sees it, kept in effective form for aiming prices.
  logic [63:0] cur_floor;
  logic [63:0] cur_step;
  int          cur_levels;

  always #6 clk = ~clk;

  price_level_ladder u_top (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  price_level_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count, .open_results
  );

  // Receiver: stall at random, or hold off entirely while a long hold runs.
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= 300;
      out_ready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one beat, holding valid and payload until accepted.
  task automatic send_beat(input logic kind, input logic [63:0] px, input logic [63:0] qty);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data.req_type <= kind;
    in_data.price    <= px;
    in_data.quantity <= qty;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (open_results != 0);
  endtask

  // Write one register through a setup and an access cycle; the block is idle.
  task automatic write_reg(input logic [1:0] regsel, input logic [63:0] value);
    drain();
    repeat (20) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {regsel, 3'b000};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_grid(input logic [63:0] flo, input logic [63:0] tck, input logic [6:0] cnt);
    write_reg(REG_FLOOR, flo);
    write_reg(REG_TICK, tck);
    write_reg(REG_COUNT, {57'd0, cnt});
    cur_floor  = flo;
    cur_step   = (tck[62:0] == 0) ? 64'd1 : {1'b0, tck[62:0]};
    cur_levels = (cnt == 0) ? 1 : (cnt > MAX_LEVELS) ? MAX_LEVELS : int'(cnt);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Aim most prices at grid levels (a few just past the top), the rest off grid.
  task automatic random_beat();
    int          pick;
    logic [63:0] px, qty;
    logic        kind;
    pick = $urandom_range(99);
    if (pick < 70)      px = cur_floor + 64'($urandom_range(cur_levels + 1)) * cur_step;
    else if (pick < 80) px = cur_floor + 64'($urandom_range(cur_levels - 1)) * cur_step + 1;
    else if (pick < 88) px = cur_floor - (($urandom_range(1)) ? cur_step : 64'd1);
    else                px = rand64();
    pick = $urandom_range(99);
    if (pick < 15)      qty = '0;
    else if (pick < 55) qty = 64'($urandom_range(1000, 1));
    else if (pick < 70) qty = ~64'($urandom_range(1000));
    else                qty = rand64();
    kind = ($urandom_range(99) < 30) ? REQ_QUERY : REQ_SET;
    send_beat(kind, px, qty);
  endtask

  initial begin
    logic [63:0] grids [8][3];
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cur_floor  = '0;
    cur_step   = 64'd1;
    cur_levels = 64;

    // Directed: default grid, empty book, extremes and both rejections.
    send_beat(REQ_QUERY, 64'd0, '0);
    send_beat(REQ_SET, 64'd0, '1);
    send_beat(REQ_SET, 64'd63, 64'd1);
    send_beat(REQ_QUERY, 64'd63, '0);
    send_beat(REQ_QUERY, 64'd64, '0);
    send_beat(REQ_SET, '1, 64'd5);
    send_beat(REQ_SET, 64'h8000_0000_0000_0000, 64'd5);
    send_beat(REQ_SET, 64'h7FFF_FFFF_FFFF_FFFF, 64'd5);
    send_beat(REQ_SET, 64'd0, '0);
    send_beat(REQ_SET, 64'd63, 64'd9);
    send_beat(REQ_SET, 64'd5, 64'hFFFF_FFFF_FFFF_FFF6);
    send_beat(REQ_SET, 64'd7, 64'd1);
    send_beat(REQ_SET, 64'd5, 64'd3);
    send_beat(REQ_QUERY, 64'd5, '1);
    send_beat(REQ_SET, 64'd0, 64'hAAAA_5555_AAAA_5555);
    send_beat(REQ_QUERY, 64'd0, 64'h5555_AAAA_5555_AAAA);

    // Off-tick and out-of-range prices on a coarser grid, below-floor prices.
    set_grid(-64'sd100, 64'd3, 7'd10);
    send_beat(REQ_SET, -64'sd100, 64'd11);
    send_beat(REQ_SET, -64'sd99, 64'd11);
    send_beat(REQ_SET, -64'sd73, 64'd12);
    send_beat(REQ_SET, -64'sd70, 64'd12);
    send_beat(REQ_QUERY, -64'sd101, '0);

    // Zero tick acts as one, zero count as one; old levels now report wrapped prices.
    set_grid(64'h7FFF_FFFF_FFFF_FFF0, '0, 7'd0);
    send_beat(REQ_SET, 64'h7FFF_FFFF_FFFF_FFF0, 64'd4);
    send_beat(REQ_QUERY, 64'h7FFF_FFFF_FFFF_FFF1, '0);

    grids[0] = '{64'h8000_0000_0000_0000, '1, 64'd127};
    grids[1] = '{rand64(), 64'($urandom_range(7, 1)), 64'd64};
    grids[2] = '{64'($urandom_range(5000)), (rand64() >> 2) | 64'h4000_0000_0000_0000,
                 64'($urandom_range(64, 1))};
    grids[3] = '{64'd1000, 64'd5, 64'd64};
    grids[4] = '{-64'sd5, 64'd1, 64'd32};
    grids[5] = '{rand64(), rand64(), 64'($urandom_range(127))};
    grids[6] = '{'0, 64'd1, 64'd64};
    grids[7] = '{64'h7FFF_FFFF_FFFF_FF00, 64'd4, 64'd64};

    for (int ph = 0; ph < 8; ph++) begin
      set_grid(grids[ph][0], grids[ph][1], grids[ph][2][6:0]);
      // Rotate through: no idling, sender idle, receiver stalling, both.
      case (ph % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 66; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 66; end
        default: begin send_gap_pct = 27; recv_stall_pct = 27; end
      endcase
      for (int n = 0; n < 60; n++) begin
        // Fill the block against a long receiver hold-off.
        if (ph == 4 && n == 10) hold_requests = hold_requests + 1;
        // Pause the sender until the book has answered everything.
        if (ph == 1 && n == 30) drain();
        random_beat();
      end
    end

    drain();
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop if handshakes hang.
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
